>>> hdl/packet_rate_shaper_core_assert.svh
// ----------------------------------------------------------------------------
// Packet rate shaper assertion macros
// Concurrent checks that are compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef PACKET_RATE_SHAPER_CORE_ASSERT_SVH
`define PACKET_RATE_SHAPER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

`define PRS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("packet rate shaper check failed");

`define PRS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("packet rate shaper check failed");

`else

`define PRS_ASSERT_IMP(lbl, ck, rs, ante, cons)

`define PRS_ASSERT_NXT(lbl, ck, rs, ante, cons)

`endif

`endif

>>> hdl/prs_pkg.sv
// ----------------------------------------------------------------------------
// Packet rate shaper package
// Beat types, widths, constants and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prs_pkg;

  localparam int TIME_BITS = 48;
  localparam int PAY_W     = 16;
  localparam int PKT_W     = 17;
  localparam int WAIT_W    = 31;
  localparam int BACKLOG_W = 32;
  localparam int RATE_W    = 31;
  localparam int DEN_W     = 31;
  localparam int REM_W     = 20;
  localparam int BITS_W    = 36;
  localparam int USEC_W    = 20;
  localparam int USEC_IW   = $clog2(USEC_W);
  localparam int PROD_W    = BITS_W + USEC_W;
  localparam int NUM_W     = (TIME_BITS > PROD_W) ? TIME_BITS : PROD_W;
  localparam int QW        = TIME_BITS - 19;
  localparam int SHW       = (QW > RATE_W) ? QW : RATE_W;
  localparam int STEP_W    = $clog2(NUM_W + 1);

  localparam logic [PKT_W-1:0]     HDR_BYTES     = 17'd28;
  localparam logic [USEC_W-1:0]    USEC_PER_SEC  = 20'd1000000;
  localparam logic [REM_W+1:0]     TWO_USEC      = 22'd2000000;
  localparam logic [WAIT_W-1:0]    WAIT_LIMIT    = 31'd40000;
  localparam logic [BACKLOG_W-1:0] BACKLOG_LIMIT = 32'd100000;
  localparam logic [WAIT_W-1:0]    WAIT_STEP     = 31'd10000;
  localparam logic [WAIT_W-1:0]    WAIT_MAX      = 31'h7FFFFFFF;
  localparam logic [RATE_W-1:0]    RATE_RESET    = 31'd1000000;

  typedef struct packed {
    logic [TIME_BITS-1:0] time_now_us;
    logic [PAY_W-1:0]     payload_bytes;
  } pkt_t;

  typedef struct packed {
    logic [WAIT_W-1:0]    wait_us;
    logic [BACKLOG_W-1:0] backlog_bytes;
  } res_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_ELAP,
    ST_MUL_Q,
    ST_FRAC,
    ST_SUM,
    ST_CMP,
    ST_MUL_REF,
    ST_DIV_REF,
    ST_MUL_SLP,
    ST_DIV_SLP,
    ST_DIV_MOD,
    ST_DONE
  } state_t;

endpackage

>>> hdl/prs_div.sv
// ----------------------------------------------------------------------------
// Packet rate shaper serial divider
// Restoring divider, one quotient bit per cycle, numerator MSB aligned.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs_div (
  input  logic                        clk,
  input  logic                        rst,
  input  prs_pkg::div_req_t           req,
  input  logic [prs_pkg::NUM_W-1:0]   num,
  input  logic [prs_pkg::DEN_W-1:0]   den,
  output logic                        busy,
  output logic [prs_pkg::NUM_W-1:0]   quot,
  output logic [prs_pkg::DEN_W-1:0]   rem
);

  logic [prs_pkg::NUM_W-1:0]  num_sh;
  logic [prs_pkg::DEN_W-1:0]  den_r;
  logic [prs_pkg::STEP_W-1:0] cnt;
  logic [prs_pkg::DEN_W:0]    trial;
  logic [prs_pkg::DEN_W:0]    diff;
  logic                       ge;

  assign trial = {rem, num_sh[prs_pkg::NUM_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt  <= req.steps;
    end else if (busy) begin
      cnt <= cnt - prs_pkg::STEP_W'(1);
      if (cnt == prs_pkg::STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_sh <= num;
      den_r  <= den;
      rem    <= '0;
      quot   <= '0;
    end else if (busy) begin
      num_sh <= {num_sh[prs_pkg::NUM_W-2:0], 1'b0};
      rem    <= ge ? diff[prs_pkg::DEN_W-1:0] : trial[prs_pkg::DEN_W-1:0];
      quot   <= {quot[prs_pkg::NUM_W-2:0], ge};
    end
  end

endmodule

>>> hdl/packet_rate_shaper_core.sv
// A packet beat is taken only in ST_IDLE; when the bucket has emptied the block
//   skips the drain, delay and modulo steps, and the next packet is taken after ST_DONE.
// Rate is set by the shared bit-serial divider (48, 56, 56 and 31 steps) and
//   the shift-add multiply and fraction loops (29, 31, 20 and 20 steps).
// Reset (rst, synchronous): bit_rate returns to 1000000, reference time and
//   backlog clear, any result beat held in the output register is dropped.
// ----------------------------------------------------------------------------
// Packet rate shaper core
// Leaky-bucket shaper: drains the backlog at bit_rate and reports the wait
// a sender must observe before the next packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "packet_rate_shaper_core_assert.svh"

module packet_rate_shaper_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prs_pkg::RATE_W-1:0]   cfg_data,
  input  logic                         pkt_valid,
  output logic                         pkt_ready,
  input  prs_pkg::pkt_t                pkt,
  output logic                         res_valid,
  input  logic                         res_ready,
  output prs_pkg::res_t                res
);

  prs_pkg::state_t state, state_next;

  logic [prs_pkg::RATE_W-1:0]    bit_rate;
  logic [prs_pkg::TIME_BITS-1:0] ref_time, ref_time_next;
  logic [prs_pkg::BACKLOG_W-1:0] backlog, backlog_next;
  logic [prs_pkg::TIME_BITS-1:0] now_r, now_r_next;
  logic [prs_pkg::PKT_W-1:0]     pkt_r, pkt_r_next;
  logic [prs_pkg::REM_W-1:0]     rem_r, rem_r_next;
  logic [prs_pkg::SHW-1:0]       sh, sh_next;
  logic [prs_pkg::STEP_W-1:0]    cnt, cnt_next;
  logic [prs_pkg::PROD_W-1:0]    acc, acc_next;
  logic                          sat, sat_next;
  logic [prs_pkg::REM_W-1:0]     fr_r, fr_r_next;
  logic [prs_pkg::RATE_W-1:0]    fr_q, fr_q_next;
  logic [prs_pkg::BITS_W-1:0]    xop, xop_next;
  logic [prs_pkg::WAIT_W-1:0]    slp, slp_next;
  logic [prs_pkg::WAIT_W-1:0]    wait_r, wait_r_next;
  logic                          res_valid_next;
  prs_pkg::res_t                 res_next;

  logic [prs_pkg::RATE_W-1:0]    rate_eff;
  logic [prs_pkg::TIME_BITS-1:0] elapsed;
  logic [37-1:0]                 mq_sum;
  logic [prs_pkg::REM_W+1:0]     fr_t;
  logic [1:0]                    fr_d;
  logic [prs_pkg::REM_W-1:0]     fr_rn;
  logic [prs_pkg::PROD_W-1:0]    mc_next;
  logic                          emptied;
  logic [prs_pkg::WAIT_W-1:0]    slp_now;
  logic [prs_pkg::BACKLOG_W:0]   bl_sum;
  logic                          report;

  prs_pkg::div_req_t             div_req;
  logic [prs_pkg::NUM_W-1:0]     div_num;
  logic [prs_pkg::DEN_W-1:0]     div_den;
  logic                          div_busy;
  logic [prs_pkg::NUM_W-1:0]     div_quot;
  logic [prs_pkg::DEN_W-1:0]     div_rem;

  prs_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (div_req),
    .num  (div_num),
    .den  (div_den),
    .busy (div_busy),
    .quot (div_quot),
    .rem  (div_rem)
  );

  assign cfg_ready = 1'b1;
  assign pkt_ready = (state == prs_pkg::ST_IDLE);

  always_comb begin
    rate_eff = (bit_rate == '0) ? prs_pkg::RATE_W'(1) : bit_rate;
    elapsed  = pkt.time_now_us - ref_time;
    mq_sum   = {acc[35:0], 1'b0} + (sh[prs_pkg::SHW-1] ? 37'(rate_eff) : 37'd0);
    fr_t     = {1'b0, fr_r, 1'b0}
             + (sh[prs_pkg::SHW-1] ? (prs_pkg::REM_W+2)'(rem_r) : '0);
    if (fr_t >= prs_pkg::TWO_USEC) begin
      fr_d  = 2'd2;
      fr_rn = prs_pkg::REM_W'(fr_t - prs_pkg::TWO_USEC);
    end else if (fr_t >= (prs_pkg::REM_W+2)'(prs_pkg::USEC_PER_SEC)) begin
      fr_d  = 2'd1;
      fr_rn = prs_pkg::REM_W'(fr_t - (prs_pkg::REM_W+2)'(prs_pkg::USEC_PER_SEC));
    end else begin
      fr_d  = 2'd0;
      fr_rn = fr_t[prs_pkg::REM_W-1:0];
    end
    mc_next = {acc[prs_pkg::PROD_W-2:0], 1'b0}
            + (prs_pkg::USEC_PER_SEC[cnt[prs_pkg::USEC_IW-1:0]]
               ? prs_pkg::PROD_W'(xop) : '0);
    emptied = sat || (xop >= {1'b0, backlog, 3'b000});
    slp_now = (|div_quot[prs_pkg::NUM_W-1:prs_pkg::WAIT_W]) ? prs_pkg::WAIT_MAX
                                                             : div_quot[prs_pkg::WAIT_W-1:0];
    bl_sum  = {1'b0, backlog} + (prs_pkg::BACKLOG_W+1)'(pkt_r);
    report  = (slp > prs_pkg::WAIT_LIMIT) || (backlog >= prs_pkg::BACKLOG_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= prs_pkg::ST_IDLE;
      res_valid <= 1'b0;
      bit_rate  <= prs_pkg::RATE_RESET;
      ref_time  <= '0;
      backlog   <= '0;
    end else begin
      state     <= state_next;
      res_valid <= res_valid_next;
      ref_time  <= ref_time_next;
      backlog   <= backlog_next;
      if (cfg_valid && cfg_ready) begin
        bit_rate <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    now_r  <= now_r_next;
    pkt_r  <= pkt_r_next;
    rem_r  <= rem_r_next;
    sh     <= sh_next;
    cnt    <= cnt_next;
    acc    <= acc_next;
    sat    <= sat_next;
    fr_r   <= fr_r_next;
    fr_q   <= fr_q_next;
    xop    <= xop_next;
    slp    <= slp_next;
    wait_r <= wait_r_next;
    res    <= res_next;
  end

  always_comb begin
    state_next     = state;
    ref_time_next  = ref_time;
    backlog_next   = backlog;
    now_r_next     = now_r;
    pkt_r_next     = pkt_r;
    rem_r_next     = rem_r;
    sh_next        = sh;
    cnt_next       = cnt;
    acc_next       = acc;
    sat_next       = sat;
    fr_r_next      = fr_r;
    fr_q_next      = fr_q;
    xop_next       = xop;
    slp_next       = slp;
    wait_r_next    = wait_r;
    res_next       = res;
    res_valid_next = res_valid && !res_ready;
    div_req        = '0;
    div_num        = '0;
    div_den        = rate_eff;

    case (state)
      prs_pkg::ST_IDLE: begin
        if (pkt_valid) begin
          now_r_next    = pkt.time_now_us;
          pkt_r_next    = prs_pkg::PKT_W'(pkt.payload_bytes) + prs_pkg::HDR_BYTES;
          div_req.start = 1'b1;
          div_req.steps = prs_pkg::STEP_W'(prs_pkg::TIME_BITS);
          div_num       = prs_pkg::NUM_W'(elapsed) << (prs_pkg::NUM_W - prs_pkg::TIME_BITS);
          div_den       = prs_pkg::DEN_W'(prs_pkg::USEC_PER_SEC);
          state_next    = prs_pkg::ST_DIV_ELAP;
        end
      end

      prs_pkg::ST_DIV_ELAP: begin
        if (!div_busy) begin
          rem_r_next = div_rem[prs_pkg::REM_W-1:0];
          sh_next    = prs_pkg::SHW'(div_quot[prs_pkg::QW-1:0]) << (prs_pkg::SHW - prs_pkg::QW);
          cnt_next   = prs_pkg::STEP_W'(prs_pkg::QW - 1);
          acc_next   = '0;
          sat_next   = 1'b0;
          state_next = prs_pkg::ST_MUL_Q;
        end
      end

      prs_pkg::ST_MUL_Q: begin
        acc_next = prs_pkg::PROD_W'(mq_sum);
        sat_next = sat || (|mq_sum[36:35]);
        sh_next  = {sh[prs_pkg::SHW-2:0], 1'b0};
        cnt_next = cnt - prs_pkg::STEP_W'(1);
        if (cnt == '0) begin
          sh_next    = prs_pkg::SHW'(rate_eff) << (prs_pkg::SHW - prs_pkg::RATE_W);
          cnt_next   = prs_pkg::STEP_W'(prs_pkg::RATE_W - 1);
          fr_r_next  = '0;
          fr_q_next  = '0;
          state_next = prs_pkg::ST_FRAC;
        end
      end

      prs_pkg::ST_FRAC: begin
        fr_r_next = fr_rn;
        fr_q_next = {fr_q[prs_pkg::RATE_W-2:0], 1'b0} + prs_pkg::RATE_W'(fr_d);
        sh_next   = {sh[prs_pkg::SHW-2:0], 1'b0};
        cnt_next  = cnt - prs_pkg::STEP_W'(1);
        if (cnt == '0) begin
          state_next = prs_pkg::ST_SUM;
        end
      end

      prs_pkg::ST_SUM: begin
        xop_next   = prs_pkg::BITS_W'(acc[34:0]) + prs_pkg::BITS_W'(fr_q);
        state_next = prs_pkg::ST_CMP;
      end

      prs_pkg::ST_CMP: begin
        if (emptied) begin
          backlog_next  = prs_pkg::BACKLOG_W'(pkt_r);
          ref_time_next = now_r;
          wait_r_next   = '0;
          state_next    = prs_pkg::ST_DONE;
        end else begin
          backlog_next = backlog - xop[34:3];
          acc_next     = '0;
          cnt_next     = prs_pkg::STEP_W'(prs_pkg::USEC_W - 1);
          state_next   = prs_pkg::ST_MUL_REF;
        end
      end

      prs_pkg::ST_MUL_REF: begin
        acc_next = mc_next;
        cnt_next = cnt - prs_pkg::STEP_W'(1);
        if (cnt == '0) begin
          div_req.start = 1'b1;
          div_req.steps = prs_pkg::STEP_W'(prs_pkg::PROD_W);
          div_num       = prs_pkg::NUM_W'(mc_next) << (prs_pkg::NUM_W - prs_pkg::PROD_W);
          state_next    = prs_pkg::ST_DIV_REF;
        end
      end

      prs_pkg::ST_DIV_REF: begin
        if (!div_busy) begin
          ref_time_next = ref_time + prs_pkg::TIME_BITS'(div_quot);
          xop_next      = {1'b0, backlog, 3'b000};
          acc_next      = '0;
          cnt_next      = prs_pkg::STEP_W'(prs_pkg::USEC_W - 1);
          state_next    = prs_pkg::ST_MUL_SLP;
        end
      end

      prs_pkg::ST_MUL_SLP: begin
        acc_next = mc_next;
        cnt_next = cnt - prs_pkg::STEP_W'(1);
        if (cnt == '0) begin
          div_req.start = 1'b1;
          div_req.steps = prs_pkg::STEP_W'(prs_pkg::PROD_W);
          div_num       = prs_pkg::NUM_W'(mc_next) << (prs_pkg::NUM_W - prs_pkg::PROD_W);
          state_next    = prs_pkg::ST_DIV_SLP;
        end
      end

      prs_pkg::ST_DIV_SLP: begin
        if (!div_busy) begin
          slp_next      = slp_now;
          div_req.start = 1'b1;
          div_req.steps = prs_pkg::STEP_W'(prs_pkg::WAIT_W);
          div_num       = prs_pkg::NUM_W'(slp_now) << (prs_pkg::NUM_W - prs_pkg::WAIT_W);
          div_den       = prs_pkg::DEN_W'(prs_pkg::WAIT_STEP);
          state_next    = prs_pkg::ST_DIV_MOD;
        end
      end

      prs_pkg::ST_DIV_MOD: begin
        if (!div_busy) begin
          if (report && (slp >= prs_pkg::WAIT_STEP)) begin
            wait_r_next = slp - div_rem - prs_pkg::WAIT_STEP;
          end else begin
            wait_r_next = '0;
          end
          backlog_next = bl_sum[prs_pkg::BACKLOG_W] ? '1 : bl_sum[prs_pkg::BACKLOG_W-1:0];
          state_next   = prs_pkg::ST_DONE;
        end
      end

      prs_pkg::ST_DONE: begin
        if (!res_valid || res_ready) begin
          res_next.wait_us       = wait_r;
          res_next.backlog_bytes = backlog;
          res_valid_next         = 1'b1;
          state_next             = prs_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = prs_pkg::ST_IDLE;
      end
    endcase
  end

  `PRS_ASSERT_IMP(a_div_start_idle, clk, rst, div_req.start, !div_busy)
  `PRS_ASSERT_NXT(a_done_loads_beat, clk, rst,
                  (state == prs_pkg::ST_DONE) && (!res_valid || res_ready),
                  res_valid && (state == prs_pkg::ST_IDLE))
  `PRS_ASSERT_NXT(a_drain_lowers_backlog, clk, rst,
                  (state == prs_pkg::ST_CMP) && !emptied,
                  backlog <= $past(backlog))

endmodule

>>> test/tb_packet_rate_shaper_core.sv
// ----------------------------------------------------------------------------
// Packet rate shaper core testbench
// Sends packet beats through the shaper and checks every result beat against
// a leaky-bucket predictor that follows the drain rate written to the block.
// Covers the field extremes, zero, minimum and maximum rates, a time that runs
// backwards, delay saturation and a long result stall, then random traffic
// with random gaps on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_packet_rate_shaper_core;

  localparam longint unsigned CYCLE_LIMIT = 3000000;
  localparam logic [63:0] TIME_MASK  = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] USEC       = 64'd1000000;
  localparam logic [63:0] DRAIN_CAP  = 64'd1 << 62;
  localparam logic [63:0] HDR_LEN    = 64'd28;
  localparam logic [63:0] DELAY_MAX  = 64'h7FFF_FFFF;
  localparam logic [63:0] DELAY_FLOOR = 64'd40000;
  localparam logic [63:0] BACKLOG_FLOOR = 64'd100000;
  localparam logic [63:0] DELAY_STEP = 64'd10000;
  localparam int          TAIL_CYCLES = 320;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [prs_pkg::RATE_W-1:0] cfg_data = '0;
  logic                       pkt_valid = 1'b0;
  logic                       pkt_ready;
  prs_pkg::pkt_t              pkt = '0;
  logic                       res_valid;
  logic                       res_ready = 1'b0;
  prs_pkg::res_t              res;

  logic [prs_pkg::RATE_W-1:0]    shaper_rate = prs_pkg::RATE_RESET;
  logic [prs_pkg::TIME_BITS-1:0] bucket_ref_us = '0;
  logic [31:0]                   bucket_backlog = '0;
  logic [prs_pkg::TIME_BITS-1:0] clock_us = '0;

  prs_pkg::res_t   pending_verdicts[$];
  int unsigned     mismatch_count = 0;
  longint unsigned cycle_count = 0;
  bit              src_idle = 1'b0;
  bit              sink_idle = 1'b0;
  int unsigned     sink_gap = 0;
  int unsigned     sink_holdoff_req = 0;
  bit              sink_holdoff_done = 1'b0;

  packet_rate_shaper_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL packet_rate_shaper_core");
      $finish;
    end
  end

  task automatic note_error(input string msg);
    mismatch_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic prs_pkg::res_t shape_packet(input prs_pkg::pkt_t p);
    logic [63:0] now_us, pkt_len, rate, elapsed, secs, frac, drained;
    logic [63:0] delay_us, owed_us, total;
    prs_pkg::res_t r;
    now_us  = 64'(p.time_now_us);
    pkt_len = 64'(p.payload_bytes) + HDR_LEN;
    rate    = (shaper_rate == '0) ? 64'd1 : 64'(shaper_rate);
    elapsed = (now_us - 64'(bucket_ref_us)) & TIME_MASK;
    secs    = elapsed / USEC;
    frac    = elapsed % USEC;
    if (secs > DRAIN_CAP / rate) drained = DRAIN_CAP;
    else drained = secs * rate + (frac * rate) / USEC;
    if (drained >= 64'(bucket_backlog) * 64'd8) begin
      bucket_backlog  = pkt_len[31:0];
      bucket_ref_us   = now_us[prs_pkg::TIME_BITS-1:0];
      r.wait_us       = '0;
      r.backlog_bytes = bucket_backlog;
      return r;
    end
    bucket_backlog = bucket_backlog - 32'(drained / 64'd8);
    bucket_ref_us  = bucket_ref_us + prs_pkg::TIME_BITS'((drained * USEC) / rate);
    delay_us = (64'(bucket_backlog) * 64'd8 * USEC) / rate;
    if (delay_us > DELAY_MAX) delay_us = DELAY_MAX;
    owed_us = '0;
    if (delay_us > DELAY_FLOOR || 64'(bucket_backlog) >= BACKLOG_FLOOR) begin
      if (delay_us >= DELAY_STEP) begin
        owed_us = delay_us - DELAY_STEP;
        owed_us = owed_us - (owed_us % DELAY_STEP);
      end
    end
    total = 64'(bucket_backlog) + pkt_len;
    bucket_backlog  = (total > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0];
    r.wait_us       = owed_us[prs_pkg::WAIT_W-1:0];
    r.backlog_bytes = bucket_backlog;
    return r;
  endfunction

  // result sink: random gaps per beat, long hold-off on request
  always @(posedge clk) begin : sink_ctl
    int unsigned g;
    if (rst) begin
      res_ready <= 1'b0;
      sink_gap  <= 0;
    end else if (sink_holdoff_req != 0 && !sink_holdoff_done) begin
      res_ready         <= 1'b0;
      sink_gap          <= sink_holdoff_req;
      sink_holdoff_done <= 1'b1;
    end else if (sink_gap != 0) begin
      sink_gap <= sink_gap - 1;
      if (sink_gap == 1) res_ready <= 1'b1;
    end else if (!res_ready) begin
      res_ready <= 1'b1;
    end else if (res_valid) begin
      g = sink_idle ? $urandom_range(0, 7) : 0;
      if (g != 0) begin
        res_ready <= 1'b0;
        sink_gap  <= g;
      end
    end
  end

  always @(posedge clk) begin : verdict_check
    prs_pkg::res_t want;
    if (!rst && res_valid && res_ready) begin
      if (pending_verdicts.size() == 0) begin
        note_error($sformatf("unexpected result beat wait=%0d backlog=%0d",
                             res.wait_us, res.backlog_bytes));
      end else begin
        want = pending_verdicts.pop_front();
        if (res.wait_us !== want.wait_us)
          note_error($sformatf("wait_us got %0d want %0d", res.wait_us, want.wait_us));
        if (res.backlog_bytes !== want.backlog_bytes)
          note_error($sformatf("backlog_bytes got %0d want %0d",
                               res.backlog_bytes, want.backlog_bytes));
      end
    end
  end

  task automatic send_packet(input logic [prs_pkg::TIME_BITS-1:0] t_us,
                             input logic [prs_pkg::PAY_W-1:0] len);
    int unsigned g;
    prs_pkg::pkt_t p;
    g = src_idle ? $urandom_range(0, 7) : 0;
    p.time_now_us   = t_us;
    p.payload_bytes = len;
    if (g != 0) begin
      pkt_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    pkt       <= p;
    pkt_valid <= 1'b1;
    do @(posedge clk); while (!pkt_ready);
    pending_verdicts.push_back(shape_packet(p));
  endtask

  task automatic await_drained();
    pkt_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_rate(input logic [prs_pkg::RATE_W-1:0] rate);
    await_drained();
    cfg_data  <= rate;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    shaper_rate  = rate;
  endtask

  task automatic test_reset_rate_extremes();
    send_packet(48'd0, 16'd0);
    send_packet(48'd0, 16'd65507);
    send_packet(48'd0, 16'd65535);
    send_packet(48'd50000, 16'd1000);
    send_packet(48'hFFFF_FFFF_FFFF, 16'd0);
    send_packet(48'd0, 16'd100);
    send_packet(48'h8000_0000_0000, 16'd65507);
    send_packet(48'h8000_0000_7530, 16'd20000);
  endtask

  task automatic test_rate_extremes();
    set_rate('0);
    send_packet(48'd1000, 16'd10);
    send_packet(48'd1000, 16'd10);
    send_packet(48'd1000, 16'd65535);
    set_rate(31'd1);
    send_packet(48'd3000000, 16'd500);
    send_packet(48'd4000000, 16'd40000);
    send_packet(48'd4000001, 16'h5A5A);
    set_rate(31'h7FFF_FFFF);
    send_packet(48'd1000, 16'd65535);
    send_packet(48'd1000, 16'd65535);
    send_packet(48'd1001, 16'd100);
    send_packet(48'd0, 16'd0);
    clock_us = '0;
  endtask

  task automatic test_result_holdoff();
    await_drained();
    src_idle  = 1'b0;
    sink_idle = 1'b0;
    @(negedge clk) sink_holdoff_req = 3000;
    @(posedge clk);
    for (int i = 0; i < 12; i++) send_packet(clock_us, 16'(i * 4000));
  endtask

  task automatic test_random_traffic();
    logic [prs_pkg::RATE_W-1:0] rates[6];
    logic [63:0] span, stride, rate_eff;
    logic [63:0] wide;
    logic [prs_pkg::PAY_W-1:0] len;
    int unsigned kind;
    rates[0] = prs_pkg::RATE_RESET;
    rates[1] = 31'd1;
    rates[2] = 31'h7FFF_FFFF;
    rates[3] = prs_pkg::RATE_W'($urandom);
    rates[4] = prs_pkg::RATE_W'($urandom_range(8000, 10000000));
    rates[5] = '0;
    for (int ph = 0; ph < 6; ph++) begin
      set_rate(rates[ph]);
      src_idle  = (ph % 4) < 2;
      sink_idle = (ph % 2) == 0;
      rate_eff = (rates[ph] == '0) ? 64'd1 : 64'(rates[ph]);
      span = 64'd200000000000 / rate_eff;
      if (span > 64'd1073741824) span = 64'd1073741824;
      if (span == 0) span = 64'd1;
      for (int i = 0; i < 220; i++) begin
        kind = $urandom_range(0, 19);
        if (kind == 0) begin
          wide = {$urandom, $urandom};
          clock_us = wide[prs_pkg::TIME_BITS-1:0];
        end else if (kind == 1) begin
          clock_us = clock_us - prs_pkg::TIME_BITS'($urandom_range(1, 1000));
        end else begin
          stride = 64'($urandom_range(0, 32'(span)));
          if (kind < 4) stride = stride * 4;
          clock_us = clock_us + prs_pkg::TIME_BITS'(stride);
        end
        case ($urandom_range(0, 3))
          0:       len = prs_pkg::PAY_W'($urandom_range(0, 64));
          1:       len = 16'hFFFF - prs_pkg::PAY_W'($urandom_range(0, 40));
          default: len = prs_pkg::PAY_W'($urandom);
        endcase
        send_packet(clock_us, len);
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_rate_extremes();
    test_rate_extremes();
    test_result_holdoff();
    test_random_traffic();
    await_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS packet_rate_shaper_core");
    end else begin
      $display("FAIL packet_rate_shaper_core");
    end
    $finish;
  end

endmodule
